/* rtl/cbb_pkg.sv */
// Shared types and constants of the color blur binarize pipeline.
// No dependencies; cbb_ctrl, cbb_window, cbb_filter and the top level import it.
package cbb_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  // configuration port
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 13;
  localparam int IMG_WIDTH_W  = 11;
  localparam int IMG_HEIGHT_W = 13;
  localparam int THRESH_W     = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COLOR_THRESHOLD = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BINARY_THRESHOLD = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PINK_GREEN      = 3'd4;

  localparam logic [IMG_WIDTH_W-1:0]  RST_IMAGE_WIDTH      = 11'd640;
  localparam logic [IMG_HEIGHT_W-1:0] RST_IMAGE_HEIGHT     = 13'd480;
  localparam logic [THRESH_W-1:0]     RST_COLOR_THRESHOLD  = 8'd50;
  localparam logic [THRESH_W-1:0]     RST_BINARY_THRESHOLD = 8'd185;
  localparam logic [THRESH_W-1:0]     RST_PINK_GREEN       = 8'd52;

  // blur sums reach 17 * 255; x / 17 == (x * 7711) >> 17 for x < 8738
  localparam int SUM_W = 13;
  localparam logic [SUM_W-1:0] DIV17_MUL = 13'd7711;
  localparam int DIV17_SHIFT = 17;

  // luma in percent: floor(sum / 100) > t  <=>  sum > 100 * t + 99
  localparam int GRAY_W   = 15;
  localparam int GRAY_R   = 30;
  localparam int GRAY_G   = 59;
  localparam int GRAY_B   = 11;
  localparam int GRAY_DIV = 100;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pixel_t;

  localparam int PIX_W = $bits(pixel_t);

  // 3x3 neighborhood, row major, index 0 top left
  typedef pixel_t [8:0] window_t;

  // item leaving the front end toward the row memory
  typedef struct packed {
    logic   load;
    logic   emit;
    logic   interior;
    logic   last;
    pixel_t px;
  } item_t;

  // control travelling with the window stage
  typedef struct packed {
    logic valid;
    logic interior;
    logic last;
  } stage_t;

endpackage

/* rtl/cbb_if.sv */
// Stream interfaces of the pipeline: pixel input and binary result output.
// Plain valid/ready channels; no package dependency.
interface cbb_pixel_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, kind, red, green, blue, input ready);
  modport sink   (input valid, kind, red, green, blue, output ready);
endinterface

interface cbb_result_if;
  logic valid;
  logic ready;
  logic white;
  logic frame_end;

  modport source (output valid, white, frame_end, input ready);
  modport sink   (input valid, white, frame_end, output ready);
endinterface

/* rtl/cbb_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module cbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/cbb_ctrl.sv */
// Front end: input transfer, frame position counters and colorize.
// Depends on cbb_pkg and cbb_pixel_if.
module cbb_ctrl import cbb_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int COL_W = $clog2(MAX_WIDTH),
  localparam int WID_W = $clog2(MAX_WIDTH + 1),
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                restart,
  input  logic [WID_W-1:0]    width,
  input  logic [ROW_W-1:0]    height,
  input  logic [THRESH_W-1:0] color_threshold,
  input  logic                ready,
  cbb_pixel_if.sink           pixels,
  output item_t               item,
  output logic [COL_W-1:0]    col
);

  logic [COL_W-1:0] in_column, in_column_next;
  logic [ROW_W-1:0] in_row, in_row_next;
  logic [COL_W-1:0] out_column, out_column_next;
  logic [ROW_W-1:0] out_row, out_row_next;

  logic [WID_W-1:0] col_inc, ocol_inc;
  logic [ROW_W-1:0] orow_inc;
  logic             draining, process, emit, last, interior, colored;
  pixel_t           px;

  function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  assign pixels.ready = ready;
  assign col = in_column;

  always_comb begin
    draining = in_row >= height;
    process  = pixels.kind ? draining : !draining;

    colored = (absdiff(pixels.red, pixels.green) > color_threshold) ||
              (absdiff(pixels.red, pixels.blue) > color_threshold) ||
              (absdiff(pixels.green, pixels.blue) > color_threshold);
    if (pixels.kind || colored) begin
      px = '0;
    end else begin
      px = '{r: pixels.red, g: pixels.green, b: pixels.blue};
    end

    col_inc = WID_W'(in_column) + 1'b1;
    if (col_inc >= width) begin
      in_column_next = '0;
      in_row_next    = in_row + 1'b1;
    end else begin
      in_column_next = col_inc[COL_W-1:0];
      in_row_next    = in_row;
    end

    // results start once the window center has a full row behind it
    emit = (in_row != '0) && !((in_row == ROW_W'(1)) && (in_column == '0));

    ocol_inc = WID_W'(out_column) + 1'b1;
    orow_inc = out_row + 1'b1;
    last     = (orow_inc >= height) && (ocol_inc >= width);
    interior = (out_column != '0) && (ocol_inc < width) &&
               (out_row != '0) && (orow_inc < height);
    if (ocol_inc >= width) begin
      out_column_next = '0;
      out_row_next    = orow_inc;
    end else begin
      out_column_next = ocol_inc[COL_W-1:0];
      out_row_next    = out_row;
    end

    item.load     = pixels.valid && ready && process;
    item.emit     = emit;
    item.interior = interior;
    item.last     = last;
    item.px       = px;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else if (item.load) begin
      in_column <= in_column_next;
      in_row    <= in_row_next;
      if (emit) begin
        if (last) begin
          // frame done: next transfer starts a new frame
          in_column  <= '0;
          in_row     <= '0;
          out_column <= '0;
          out_row    <= '0;
        end else begin
          out_column <= out_column_next;
          out_row    <= out_row_next;
        end
      end
    end
  end

endmodule

/* rtl/cbb_window.sv */
// Row memory read-modify-write and the 3x3 window registers.
// Depends on cbb_pkg and cbb_ram.
module cbb_window import cbb_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int COL_W = $clog2(MAX_WIDTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  item_t            item,
  input  logic [COL_W-1:0] col,
  input  logic             take,
  output logic             ready,
  output window_t          win,
  output stage_t           ctl
);

  localparam int ENTRY_W = 2 * PIX_W;

  logic             s1_valid, s1_emit, s1_interior, s1_last, s1_fwd;
  pixel_t           s1_px, fwd_a, fwd_b;
  logic [COL_W-1:0] s1_col;
  logic             s2_valid, s2_interior, s2_last;
  logic             en2, advance;
  logic [ENTRY_W-1:0] rdata;
  pixel_t           row_a, row_b;

  assign en2     = !s2_valid || take;
  assign ready   = !s1_valid || en2;
  assign advance = s1_valid && en2;
  assign ctl     = '{valid: s2_valid, interior: s2_interior, last: s2_last};

  // entry = {row above, two rows above}; a same-column write at the read edge
  // (single-pixel rows) is taken from the forward registers
  always_comb begin
    if (s1_fwd) begin
      row_a = fwd_a;
      row_b = fwd_b;
    end else begin
      row_a = rdata[ENTRY_W-1 -: PIX_W];
      row_b = rdata[PIX_W-1:0];
    end
  end

  cbb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_WIDTH)
  ) u_rows (
    .clk   (clk),
    .we    (advance),
    .waddr (s1_col),
    .wdata ({s1_px, row_a}),
    .re    (item.load),
    .raddr (col),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (ready) begin
        s1_valid <= item.load;
      end
      if (en2) begin
        s2_valid <= s1_valid && s1_emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item.load) begin
      s1_px       <= item.px;
      s1_col      <= col;
      s1_emit     <= item.emit;
      s1_interior <= item.interior;
      s1_last     <= item.last;
      s1_fwd      <= s1_valid && (s1_col == col);
      fwd_a       <= s1_px;
      fwd_b       <= row_a;
    end
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        win[i*3]     <= win[i*3 + 1];
        win[i*3 + 1] <= win[i*3 + 2];
      end
      win[2]      <= row_b;
      win[5]      <= row_a;
      win[8]      <= s1_px;
      s2_interior <= s1_interior;
      s2_last     <= s1_last;
    end
  end

endmodule

/* rtl/cbb_filter.sv */
// Blur sums, divide by 17, binarize and the output register.
// Depends on cbb_pkg and cbb_result_if.
module cbb_filter import cbb_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  window_t             win,
  input  stage_t              ctl,
  input  logic [THRESH_W-1:0] binary_threshold,
  input  logic [THRESH_W-1:0] pink_green_threshold,
  output logic                take,
  cbb_result_if.source        results
);

  localparam logic [2:0] BLUR_WEIGHT [9] = '{3'd1, 3'd2, 3'd1,
                                             3'd2, 3'd5, 3'd2,
                                             3'd1, 3'd2, 3'd1};

  logic [SUM_W-1:0]   sum_r, sum_g, sum_b;
  logic [SUM_W-1:0]   s3_r, s3_g, s3_b;
  pixel_t             s3_center;
  logic               s3_valid, s3_interior, s3_last;
  logic [2*SUM_W-1:0] prod_r, prod_g, prod_b;
  pixel_t             s4_px;
  logic               s4_valid, s4_last;
  logic [GRAY_W-1:0]  gray, gray_limit;
  logic               pink;
  logic               o_valid, o_white, o_frame_end;
  logic               en4, en_out;

  assign en_out = !o_valid || results.ready;
  assign en4    = !s4_valid || en_out;
  assign take   = !s3_valid || en4;

  assign results.valid     = o_valid;
  assign results.white     = o_white;
  assign results.frame_end = o_frame_end;

  always_comb begin
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int i = 0; i < 9; i++) begin
      sum_r = sum_r + SUM_W'(win[i].r) * SUM_W'(BLUR_WEIGHT[i]);
      sum_g = sum_g + SUM_W'(win[i].g) * SUM_W'(BLUR_WEIGHT[i]);
      sum_b = sum_b + SUM_W'(win[i].b) * SUM_W'(BLUR_WEIGHT[i]);
    end
  end

  assign prod_r = (2*SUM_W)'(s3_r) * (2*SUM_W)'(DIV17_MUL);
  assign prod_g = (2*SUM_W)'(s3_g) * (2*SUM_W)'(DIV17_MUL);
  assign prod_b = (2*SUM_W)'(s3_b) * (2*SUM_W)'(DIV17_MUL);

  always_comb begin
    gray = GRAY_W'(s4_px.r) * GRAY_W'(GRAY_R) + GRAY_W'(s4_px.g) * GRAY_W'(GRAY_G) +
           GRAY_W'(s4_px.b) * GRAY_W'(GRAY_B);
    gray_limit = GRAY_W'(binary_threshold) * GRAY_W'(GRAY_DIV) + GRAY_W'(GRAY_DIV - 1);
    pink = (s4_px.r > binary_threshold) && (s4_px.b > (binary_threshold >> 1)) &&
           (s4_px.g < pink_green_threshold);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (take) begin
        s3_valid <= ctl.valid;
      end
      if (en4) begin
        s4_valid <= s3_valid;
      end
      if (en_out) begin
        o_valid <= s4_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && ctl.valid) begin
      s3_r        <= sum_r;
      s3_g        <= sum_g;
      s3_b        <= sum_b;
      s3_center   <= win[4];
      s3_interior <= ctl.interior;
      s3_last     <= ctl.last;
    end
    if (en4 && s3_valid) begin
      if (s3_interior) begin
        s4_px.r <= prod_r[DIV17_SHIFT +: 8];
        s4_px.g <= prod_g[DIV17_SHIFT +: 8];
        s4_px.b <= prod_b[DIV17_SHIFT +: 8];
      end else begin
        s4_px <= s3_center;
      end
      s4_last <= s3_last;
    end
    if (en_out && s4_valid) begin
      o_white     <= !pink && (gray > gray_limit);
      o_frame_end <= s4_last;
    end
  end

endmodule

/* rtl/color_blur_binarize_pipeline.sv */
// Top level of the color blur binarize pipeline: configuration registers
// and the stage chain. Depends on cbb_pkg, cbb_if, cbb_ctrl, cbb_window, cbb_filter.
//
// Usage:
//   pixels  : raster RGB stream; kind 0 is a pixel, kind 1 a flush tick.
//             Pixels past the frame end and flushes inside the frame are
//             taken and dropped. After the last pixel send image_width + 1
//             flush ticks to drain the frame.
//   results : one bit per pixel (white), frame_end on the frame's last one.
//   cfg_*   : write-only registers, indexed as listed in cbb_pkg; writing
//             width or height restarts the frame. Write only while idle.
// Timing: one transfer per cycle in each direction while results.ready holds. The
// result for a pixel is registered in the output register once the item that
// completes its 3x3 window (image_width + 1 items later) has passed the stages
// row memory read, window, blur sums, divide, binarize.
// Reset clears position counters, config registers and stage valids; the row memory
// is not cleared, since stale entries reach only window cells that no result uses.
// When results stalls, the stages fill up and then pixels.ready drops;
// it returns in the same cycle that results.ready does.
module color_blur_binarize_pipeline import cbb_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  cbb_pixel_if.sink              pixels,
  cbb_result_if.source           results
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2);

  logic [IMG_WIDTH_W-1:0]  image_width;
  logic [IMG_HEIGHT_W-1:0] image_height;
  logic [THRESH_W-1:0]     color_threshold, binary_threshold, pink_green_threshold;

  logic [WID_W-1:0] eff_width;
  logic [ROW_W-1:0] eff_height;
  logic             restart, win_ready, take3;
  item_t            item;
  logic [COL_W-1:0] col;
  window_t          win;
  stage_t           s2_ctl;

  assign restart = cfg_we && ((cfg_index == REG_IMAGE_WIDTH) ||
                              (cfg_index == REG_IMAGE_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width          <= RST_IMAGE_WIDTH;
      image_height         <= RST_IMAGE_HEIGHT;
      color_threshold      <= RST_COLOR_THRESHOLD;
      binary_threshold     <= RST_BINARY_THRESHOLD;
      pink_green_threshold <= RST_PINK_GREEN;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:      image_width          <= cfg_data[IMG_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT:     image_height         <= cfg_data[IMG_HEIGHT_W-1:0];
        REG_COLOR_THRESHOLD:  color_threshold      <= cfg_data[THRESH_W-1:0];
        REG_BINARY_THRESHOLD: binary_threshold     <= cfg_data[THRESH_W-1:0];
        REG_PINK_GREEN:       pink_green_threshold <= cfg_data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // frame size clamped to 1..max
  always_comb begin
    if (image_width == '0) begin
      eff_width = WID_W'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      eff_width = WID_W'(MAX_WIDTH);
    end else begin
      eff_width = WID_W'(image_width);
    end
    if (image_height == '0) begin
      eff_height = ROW_W'(1);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      eff_height = ROW_W'(MAX_HEIGHT);
    end else begin
      eff_height = ROW_W'(image_height);
    end
  end

  cbb_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .restart         (restart),
    .width           (eff_width),
    .height          (eff_height),
    .color_threshold (color_threshold),
    .ready           (win_ready),
    .pixels          (pixels),
    .item            (item),
    .col             (col)
  );

  cbb_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk   (clk),
    .rst   (rst),
    .item  (item),
    .col   (col),
    .take  (take3),
    .ready (win_ready),
    .win   (win),
    .ctl   (s2_ctl)
  );

  cbb_filter u_filter (
    .clk                  (clk),
    .rst                  (rst),
    .win                  (win),
    .ctl                  (s2_ctl),
    .binary_threshold     (binary_threshold),
    .pink_green_threshold (pink_green_threshold),
    .take                 (take3),
    .results              (results)
  );

`ifndef NO_ASSERTIONS
  a_reset_idle: assert property (@(posedge clk) rst |=> !results.valid)
    else $error("result valid right after reset");

  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    results.ready |-> pixels.ready)
    else $error("input stalled although the output is ready");

  a_window_hold: assert property (@(posedge clk) disable iff (rst)
    s2_ctl.valid && !take3 |=> s2_ctl.valid && $stable(win))
    else $error("window changed under a stalled item");
`endif

endmodule

/* test/tb_color_blur_binarize_pipeline.sv */
// Testbench for color_blur_binarize_pipeline: drives pixel/flush items with random gaps, stalls
// the result channel and checks every binarized bit against an in-bench pipeline predictor.
// Depends on rtl/cbb_pkg.sv, rtl/cbb_if.sv and the RTL of the block.
`timescale 1ns / 1ps

module tb_color_blur_binarize_pipeline;
  import cbb_pkg::*;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;
  // unused register index: writes must have no effect
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;

  // drain allowance after the last expected result, with margin on top
  localparam int PIPE_CYCLES  = 10;
  localparam int TAIL_CYCLES  = 20;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 1900;

  typedef struct packed {
    logic white;
    logic frame_end;
  } bit_result_t;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_RUNS} stall_mode_t;

  logic clk;
  logic rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  cbb_pixel_if  pix_bus ();
  cbb_result_if res_bus ();

  color_blur_binarize_pipeline DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pixels   (pix_bus),
    .results  (res_bus)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  logic [IMG_WIDTH_W-1:0]  img_w;
  logic [IMG_HEIGHT_W-1:0] img_h;
  logic [THRESH_W-1:0]     color_thr;
  logic [THRESH_W-1:0]     bin_thr;
  logic [THRESH_W-1:0]     pink_thr;

  pixel_t      row_above  [DEF_MAX_WIDTH];
  pixel_t      row_above2 [DEF_MAX_WIDTH];
  window_t     nbhd;
  int unsigned in_col, in_row, out_col, out_row;

  bit_result_t expected_bits [$];
  int          mismatch_count = 0;
  int          effective_items = 0;
  bit          frame_closed = 1'b0;
  int          burst_left = 0;
  int unsigned cycle_count = 0;

  function automatic int unsigned frame_w();
    if (img_w == 0) return 1;
    if (img_w > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
    return img_w;
  endfunction

  function automatic int unsigned frame_h();
    if (img_h == 0) return 1;
    if (img_h > DEF_MAX_HEIGHT) return DEF_MAX_HEIGHT;
    return img_h;
  endfunction

  function automatic bit pixels_complete();
    return in_row >= frame_h();
  endfunction

  function automatic void restart_positions();
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  function automatic void reset_model();
    img_w     = RST_IMAGE_WIDTH;
    img_h     = RST_IMAGE_HEIGHT;
    color_thr = RST_COLOR_THRESHOLD;
    bin_thr   = RST_BINARY_THRESHOLD;
    pink_thr  = RST_PINK_GREEN;
    foreach (row_above[i]) begin
      row_above[i]  = '0;
      row_above2[i] = '0;
    end
    nbhd = '0;
    restart_positions();
  endfunction

  function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_IMAGE_WIDTH: begin
        img_w = d[IMG_WIDTH_W-1:0];
        restart_positions();
      end
      REG_IMAGE_HEIGHT: begin
        img_h = d[IMG_HEIGHT_W-1:0];
        restart_positions();
      end
      REG_COLOR_THRESHOLD:  color_thr = d[THRESH_W-1:0];
      REG_BINARY_THRESHOLD: bin_thr   = d[THRESH_W-1:0];
      REG_PINK_GREEN:       pink_thr  = d[THRESH_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic int unsigned absdiff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
  endfunction

  function automatic pixel_t colorize(input pixel_t p);
    if (absdiff(p.r, p.g) > color_thr || absdiff(p.r, p.b) > color_thr ||
        absdiff(p.g, p.b) > color_thr)
      return '0;
    return p;
  endfunction

  function automatic int unsigned blur_weight(input int i);
    case (i)
      4:          return 5;
      1, 3, 5, 7: return 2;
      default:    return 1;
    endcase
  endfunction

  function automatic pixel_t blur3x3(input window_t wnd);
    int unsigned sr, sg, sb;
    pixel_t      o;
    int          i;
    sr = 0;
    sg = 0;
    sb = 0;
    for (i = 0; i < 9; i++) begin
      sr += int'(wnd[i].r) * blur_weight(i);
      sg += int'(wnd[i].g) * blur_weight(i);
      sb += int'(wnd[i].b) * blur_weight(i);
    end
    o.r = 8'(sr / 17);
    o.g = 8'(sg / 17);
    o.b = 8'(sb / 17);
    return o;
  endfunction

  function automatic logic binarize(input pixel_t p);
    int unsigned gray;
    // pinkish pixels are forced black
    if (p.r > bin_thr && p.b > (bin_thr >> 1) && p.g < pink_thr) return 1'b0;
    gray = (30 * int'(p.r) + 59 * int'(p.g) + 11 * int'(p.b)) / 100;
    return gray > bin_thr;
  endfunction

  // One stream item through the pipeline. Returns 0 when the item is dropped.
  function automatic bit predict_binary_pixel(input logic kind, input pixel_t raw,
                                              output bit has_res,
                                              output bit_result_t res);
    int unsigned w, h, pos;
    pixel_t      px, center;
    int          i;
    w       = frame_w();
    h       = frame_h();
    has_res = 1'b0;
    res     = '0;
    if (kind == KIND_PIXEL) begin
      if (in_row >= h) return 1'b0;
      px = colorize(raw);
    end else begin
      if (in_row < h) return 1'b0;
      px = '0;
    end
    if (in_col >= w) in_col = 0;
    pos = in_row * w + in_col;

    for (i = 0; i < 3; i++) begin
      nbhd[i*3]   = nbhd[i*3+1];
      nbhd[i*3+1] = nbhd[i*3+2];
    end
    nbhd[2] = row_above2[in_col];
    nbhd[5] = row_above[in_col];
    nbhd[8] = px;
    row_above2[in_col] = row_above[in_col];
    row_above[in_col]  = px;

    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (pos < w + 1) return 1'b1;

    if (out_col >= 1 && out_col + 1 < w && out_row >= 1 && out_row + 1 < h)
      center = blur3x3(nbhd);
    else
      center = nbhd[4];
    res.white     = binarize(center);
    res.frame_end = (out_row + 1 >= h && out_col + 1 >= w);
    has_res       = 1'b1;
    if (res.frame_end) begin
      restart_positions();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic logic [7:0] clamp8(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    int     base, sp;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        // near gray, so it survives colorize; often close to the gray threshold
        base = $urandom_range(0, 1) ? int'($urandom_range(0, 255))
                                    : int'(bin_thr) + int'($urandom_range(0, 40)) - 20;
        sp   = color_thr / 2;
        p.r  = clamp8(base + int'($urandom_range(0, 2 * sp)) - sp);
        p.g  = clamp8(base + int'($urandom_range(0, 2 * sp)) - sp);
        p.b  = clamp8(base + int'($urandom_range(0, 2 * sp)) - sp);
      end
      4, 5: begin
        // around the pink test boundaries
        p.r = 8'($urandom_range(255, bin_thr));
        p.g = 8'($urandom_range(0, pink_thr));
        p.b = 8'($urandom_range(255, bin_thr >> 1));
      end
      6: begin
        p.r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        p.g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        p.b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      default: {p.r, p.g, p.b} = 24'($urandom);
    endcase
    return p;
  endfunction

  function automatic pixel_t noise_pixel();
    pixel_t p;
    {p.r, p.g, p.b} = 24'($urandom);
    return p;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_thresh();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // Sends one item; returns after its transfer, with the predictor updated.
  task automatic push_stream_item(input logic kind, input pixel_t px);
    int          gap;
    bit          moved, has_res;
    bit_result_t res;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        pix_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 300)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    pix_bus.valid <= 1'b1;
    pix_bus.kind  <= kind;
    pix_bus.red   <= px.r;
    pix_bus.green <= px.g;
    pix_bus.blue  <= px.b;
    do @(posedge clk); while (!pix_bus.ready);
    moved = predict_binary_pixel(kind, px, has_res, res);
    if (moved) effective_items++;
    if (has_res) begin
      expected_bits.push_back(res);
      if (res.frame_end) frame_closed = 1'b1;
    end
  endtask

  task automatic wait_idle();
    pix_bus.valid <= 1'b0;
    while (expected_bits.size() != 0) @(posedge clk);
    repeat (PIPE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                           input logic [CFG_DATA_W-1:0] ct, input logic [CFG_DATA_W-1:0] bt,
                           input logic [CFG_DATA_W-1:0] pg, input bit sizes_only);
    logic [CFG_DATA_W-1:0]  vals  [8];
    logic [CFG_INDEX_W-1:0] order [6];
    int n, i;
    vals[REG_IMAGE_WIDTH]      = w;
    vals[REG_IMAGE_HEIGHT]     = h;
    vals[REG_COLOR_THRESHOLD]  = ct;
    vals[REG_BINARY_THRESHOLD] = bt;
    vals[REG_PINK_GREEN]       = pg;
    vals[REG_SPARE]            = 13'($urandom);
    // junk above the register width must be dropped
    if ($urandom_range(0, 3) == 0)
      vals[REG_COLOR_THRESHOLD][CFG_DATA_W-1:THRESH_W] = 5'($urandom);
    if ($urandom_range(0, 3) == 0)
      vals[REG_BINARY_THRESHOLD][CFG_DATA_W-1:THRESH_W] = 5'($urandom);
    if ($urandom_range(0, 3) == 0)
      vals[REG_PINK_GREEN][CFG_DATA_W-1:THRESH_W] = 5'($urandom);
    order[0] = REG_IMAGE_WIDTH;
    order[1] = REG_IMAGE_HEIGHT;
    order[2] = REG_COLOR_THRESHOLD;
    order[3] = REG_BINARY_THRESHOLD;
    order[4] = REG_PINK_GREEN;
    order[5] = REG_SPARE;
    n = sizes_only ? 2 : 6;
    for (i = 0; i < n; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= order[i];
      cfg_data  <= vals[order[i]];
      @(posedge clk);
      apply_reg(order[i], vals[order[i]]);
    end
    cfg_we <= 1'b0;
  endtask

  // Random frame with stray flushes inside and stray pixels in the drain.
  // abort_odds != 0: chance per pixel of 1/abort_odds to stop partway.
  task automatic run_frame(input int unsigned abort_odds, output bit aborted);
    aborted      = 1'b0;
    frame_closed = 1'b0;
    while (!pixels_complete()) begin
      if (abort_odds != 0 && $urandom_range(1, abort_odds) == 1) begin
        aborted = 1'b1;
        return;
      end
      if ($urandom_range(0, 15) == 0) push_stream_item(KIND_FLUSH, noise_pixel());
      push_stream_item(KIND_PIXEL, rand_pixel());
    end
    while (!frame_closed) begin
      if ($urandom_range(0, 7) == 0) push_stream_item(KIND_PIXEL, rand_pixel());
      push_stream_item(KIND_FLUSH, noise_pixel());
    end
  endtask

  // ---------------------------------------------------------------- tests
  // 3x3 frame with reset thresholds, stray flush inside and stray pixel in drain
  task automatic test_reset_thresholds();
    pixel_t pix [9];
    int     i;
    pix[0] = '{r: 8'd255, g: 8'd255, b: 8'd255};
    pix[1] = '{r: 8'd0,   g: 8'd0,   b: 8'd0};
    pix[2] = '{r: 8'd200, g: 8'd40,  b: 8'd100};
    pix[3] = '{r: 8'd186, g: 8'd186, b: 8'd186};
    pix[4] = '{r: 8'd255, g: 8'd240, b: 8'd230};
    pix[5] = '{r: 8'd185, g: 8'd185, b: 8'd185};
    pix[6] = '{r: 8'd230, g: 8'd180, b: 8'd200};
    pix[7] = '{r: 8'd255, g: 8'd205, b: 8'd255};
    pix[8] = '{r: 8'd190, g: 8'd190, b: 8'd190};
    configure(13'd3, 13'd3, '0, '0, '0, 1'b1);
    frame_closed = 1'b0;
    for (i = 0; i < 9; i++) begin
      if (i == 4) push_stream_item(KIND_FLUSH, noise_pixel());
      push_stream_item(KIND_PIXEL, pix[i]);
    end
    push_stream_item(KIND_PIXEL, pix[0]);
    while (!frame_closed) push_stream_item(KIND_FLUSH, noise_pixel());
    // frame is over: this flush is dropped again
    push_stream_item(KIND_FLUSH, noise_pixel());
  endtask

  // zero sizes clamp to a 1x1 frame; pink test on and off
  task automatic test_pink_single_pixel();
    wait_idle();
    configure(13'd0, 13'd0, 13'd255, 13'd185, 13'd52, 1'b0);
    frame_closed = 1'b0;
    push_stream_item(KIND_PIXEL, '{r: 8'd200, g: 8'd40, b: 8'd100});
    while (!frame_closed) push_stream_item(KIND_FLUSH, noise_pixel());
    frame_closed = 1'b0;
    push_stream_item(KIND_PIXEL, '{r: 8'd200, g: 8'd52, b: 8'd250});
    while (!frame_closed) push_stream_item(KIND_FLUSH, noise_pixel());
  endtask

  task automatic test_threshold_extremes();
    wait_idle();
    configure(13'd2, 13'd1, 13'd0, 13'd0, 13'd255, 1'b0);
    frame_closed = 1'b0;
    push_stream_item(KIND_PIXEL, '{r: 8'd255, g: 8'd255, b: 8'd255});
    push_stream_item(KIND_PIXEL, '{r: 8'd0, g: 8'd0, b: 8'd1});
    while (!frame_closed) push_stream_item(KIND_FLUSH, noise_pixel());
  endtask

  // size write in the middle of a frame restarts it
  task automatic test_frame_restart();
    int i;
    bit aborted;
    wait_idle();
    configure(13'd3, 13'd3, 13'd255, 13'd100, 13'd60, 1'b0);
    for (i = 0; i < 5; i++) push_stream_item(KIND_PIXEL, rand_pixel());
    wait_idle();
    configure(13'd2, 13'd2, '0, '0, '0, 1'b1);
    run_frame(0, aborted);
  endtask

  // widths and heights past the maximum, random content
  task automatic test_size_clamp();
    bit aborted;
    wait_idle();
    configure(13'd2047, 13'd1, pick_thresh(), pick_thresh(), pick_thresh(), 1'b0);
    run_frame(0, aborted);
    wait_idle();
    configure(13'd1, 13'd8191, pick_thresh(), pick_thresh(), pick_thresh(), 1'b0);
    run_frame(0, aborted);
  endtask

  task automatic test_random_frames();
    int unsigned w, h, goal;
    bit          aborted;
    goal    = effective_items + RANDOM_ITEMS;
    aborted = 1'b1;
    while (effective_items < goal) begin
      if (aborted || $urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6: begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 6);
          end
          7, 8: begin
            w = $urandom_range(9, 40);
            h = $urandom_range(1, 12);
          end
          default: begin
            w = $urandom_range(1, 3);
            h = $urandom_range(1, 3);
          end
        endcase
        wait_idle();
        configure(13'(w), 13'(h), pick_thresh(), pick_thresh(), pick_thresh(),
                  $urandom_range(0, 4) == 0);
      end
      run_frame(frame_w() * frame_h() * 8, aborted);
    end
  endtask

  // ---------------------------------------------------------------- checking
  function automatic void note_mismatch(input string field, input logic want,
                                        input logic got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s mismatch: expected %b, got %b", $realtime, field, want, got);
  endfunction

  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left = 0;
  int          run_left = 0;
  logic        run_level = 1'b1;

  always @(posedge clk) begin
    bit_result_t want;
    if (rst) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (expected_bits.size() == 0) begin
          note_mismatch("unexpected result", 1'bx, res_bus.white);
        end else begin
          want = expected_bits.pop_front();
          if (res_bus.white !== want.white)
            note_mismatch("white", want.white, res_bus.white);
          if (res_bus.frame_end !== want.frame_end)
            note_mismatch("frame_end", want.frame_end, res_bus.frame_end);
        end
      end
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 2));
        mode_left  = $urandom_range(20, 200);
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE:   res_bus.ready <= 1'b1;
        STALL_RANDOM: res_bus.ready <= ($urandom_range(0, 2) != 0);
        default: begin
          if (run_left == 0) begin
            run_level = ~run_level;
            run_left  = $urandom_range(1, 10);
          end
          run_left--;
          res_bus.ready <= run_level;
        end
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    pix_bus.valid = 1'b0;
    pix_bus.kind  = KIND_PIXEL;
    pix_bus.red   = '0;
    pix_bus.green = '0;
    pix_bus.blue  = '0;
    res_bus.ready = 1'b0;
    reset_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_thresholds();
    test_pink_single_pixel();
    test_threshold_extremes();
    test_frame_restart();
    test_size_clamp();
    test_random_frames();

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_bits.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
